### rtl/core/eir_vfp_pkg.sv
// Package for the EIR vendor field parser: beat and result types, parse phases,
// register indexes and the field constants used by the parser, result register, top and testbench.
// No dependencies.
`default_nettype none

package eir_vfp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_beat_t;

  typedef struct packed {
    logic       type_found;
    logic [1:0] headset_kind;
    logic       info_valid;
    logic [7:0] info_type_byte;
    logic [7:0] info_frames_byte;
    logic       feature_found;
    logic [7:0] info_feature_byte;
  } result_t;

  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_FIELD   = 2'd1,
    PH_STOPPED = 2'd2
  } parse_phase_t;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPANY_ID = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMMAND    = 1'd1;

  localparam logic [15:0] RESET_COMPANY_ID = 16'h005D;
  localparam logic [7:0]  RESET_COMMAND    = 8'h08;

  // Field layout.
  localparam logic [7:0] AD_TYPE_VENDOR  = 8'hFF;
  localparam logic [7:0] MIN_VENDOR_LEN  = 8'd5;
  localparam logic [7:0] FEATURE_LEN     = 8'd9;
  localparam logic [7:0] POS_AD_TYPE     = 8'd1;
  localparam logic [7:0] POS_COMPANY_LO  = 8'd2;
  localparam logic [7:0] POS_COMPANY_HI  = 8'd3;
  localparam logic [7:0] POS_COMMAND     = 8'd4;
  localparam logic [7:0] POS_INFO_TYPE   = 8'd5;
  localparam logic [7:0] POS_INFO_FRAMES = 8'd6;
  localparam logic [7:0] POS_FEATURE     = 8'd9;

endpackage

`default_nettype wire

### rtl/core/eir_vfp_if.sv
// Handshake interfaces for the EIR vendor field parser: byte input channel and
// result output channel. No dependencies.
`default_nettype none

interface eir_vfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface eir_vfp_result_if;
  logic       valid;
  logic       ready;
  logic       type_found;
  logic [1:0] headset_kind;
  logic       info_valid;
  logic [7:0] info_type_byte;
  logic [7:0] info_frames_byte;
  logic       feature_found;
  logic [7:0] info_feature_byte;

  modport source (output valid, output type_found, output headset_kind,
                  output info_valid, output info_type_byte, output info_frames_byte,
                  output feature_found, output info_feature_byte, input ready);
  modport sink   (input valid, input type_found, input headset_kind,
                  input info_valid, input info_type_byte, input info_frames_byte,
                  input feature_found, input info_feature_byte, output ready);
endinterface

`default_nettype wire

### rtl/core/eir_vfp_parser.sv
// Field walker of the EIR vendor field parser: length/type/data state, the
// per-field capture registers and the committed headset information.
// Depends on eir_vfp_pkg.
`default_nettype none

module eir_vfp_parser
  import eir_vfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        beat_en,
  input  byte_beat_t  beat,
  input  logic [15:0] vendor_id,
  input  logic [7:0]  command_code,
  output result_t     result
);

  parse_phase_t phase, phase_next;
  logic [7:0] field_length, field_length_next;
  logic [7:0] field_position, field_position_next;
  logic [7:0] ad_type_seen, ad_type_seen_next;
  logic [7:0] company_low, company_low_next;
  logic [7:0] company_high, company_high_next;
  logic [7:0] command_seen, command_seen_next;
  logic [7:0] pend_type, pend_type_next;
  logic [7:0] pend_frames, pend_frames_next;
  logic [7:0] pend_feature, pend_feature_next;
  result_t    committed, committed_next;
  logic       field_done;

  always_comb begin
    phase_next          = phase;
    field_length_next   = field_length;
    field_position_next = field_position;
    ad_type_seen_next   = ad_type_seen;
    company_low_next    = company_low;
    company_high_next   = company_high;
    command_seen_next   = command_seen;
    pend_type_next      = pend_type;
    pend_frames_next    = pend_frames;
    pend_feature_next   = pend_feature;
    field_done          = 1'b0;

    unique case (phase)
      PH_LENGTH: begin
        if (beat.data_byte == 8'd0) begin
          phase_next = PH_STOPPED;
        end else begin
          field_length_next   = beat.data_byte;
          field_position_next = 8'd0;
          ad_type_seen_next   = 8'd0;
          company_low_next    = 8'd0;
          company_high_next   = 8'd0;
          command_seen_next   = 8'd0;
          pend_type_next      = 8'd0;
          pend_frames_next    = 8'd0;
          pend_feature_next   = 8'd0;
          phase_next          = PH_FIELD;
        end
      end
      PH_FIELD: begin
        field_position_next = field_position + 8'd1;
        case (field_position_next)
          POS_AD_TYPE:     ad_type_seen_next = beat.data_byte;
          POS_COMPANY_LO:  company_low_next  = beat.data_byte;
          POS_COMPANY_HI:  company_high_next = beat.data_byte;
          POS_COMMAND:     command_seen_next = beat.data_byte;
          POS_INFO_TYPE:   pend_type_next    = beat.data_byte;
          POS_INFO_FRAMES: pend_frames_next  = beat.data_byte;
          POS_FEATURE:     pend_feature_next = beat.data_byte;
          default: ;
        endcase
        if (field_position_next >= field_length) begin
          field_done = 1'b1;
          phase_next = PH_LENGTH;
        end
      end
      PH_STOPPED: ;
      default: phase_next = PH_STOPPED;
    endcase
  end

  // Commit at the field's last byte, using the bytes captured up to and
  // including that byte.
  always_comb begin
    committed_next = committed;
    if (field_done && ad_type_seen_next == AD_TYPE_VENDOR &&
        field_length > MIN_VENDOR_LEN && command_seen_next == command_code) begin
      committed_next.type_found   = 1'b1;
      committed_next.headset_kind = {pend_type_next[0], pend_type_next[1]};
      if ({company_high_next, company_low_next} == vendor_id) begin
        committed_next.info_valid       = 1'b1;
        committed_next.info_type_byte   = pend_type_next;
        committed_next.info_frames_byte = pend_frames_next;
        if (field_length >= FEATURE_LEN) begin
          committed_next.feature_found     = 1'b1;
          committed_next.info_feature_byte = pend_feature_next;
        end
      end
    end
  end

  assign result = committed_next;

  always_ff @(posedge clk) begin
    if (rst || (beat_en && beat.last_byte)) begin
      phase          <= PH_LENGTH;
      field_length   <= 8'd0;
      field_position <= 8'd0;
      ad_type_seen   <= 8'd0;
      company_low    <= 8'd0;
      company_high   <= 8'd0;
      command_seen   <= 8'd0;
      pend_type      <= 8'd0;
      pend_frames    <= 8'd0;
      pend_feature   <= 8'd0;
      committed      <= '0;
    end else if (beat_en) begin
      phase          <= phase_next;
      field_length   <= field_length_next;
      field_position <= field_position_next;
      ad_type_seen   <= ad_type_seen_next;
      company_low    <= company_low_next;
      company_high   <= company_high_next;
      command_seen   <= command_seen_next;
      pend_type      <= pend_type_next;
      pend_frames    <= pend_frames_next;
      pend_feature   <= pend_feature_next;
      committed      <= committed_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/eir_vfp_out_reg.sv
// Result register of the EIR vendor field parser: holds one result beat until
// the receiver takes it. Depends on eir_vfp_pkg and eir_vfp_result_if.
`default_nettype none

module eir_vfp_out_reg
  import eir_vfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result,
  output logic    can_load,
  eir_vfp_result_if.source out_ch
);

  logic    out_valid;
  result_t out_data;

  assign can_load = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.type_found        = out_data.type_found;
  assign out_ch.headset_kind      = out_data.headset_kind;
  assign out_ch.info_valid        = out_data.info_valid;
  assign out_ch.info_type_byte    = out_data.info_type_byte;
  assign out_ch.info_frames_byte  = out_data.info_frames_byte;
  assign out_ch.feature_found     = out_data.feature_found;
  assign out_ch.info_feature_byte = out_data.info_feature_byte;

endmodule

`default_nettype wire

### rtl/core/eir_vendor_field_parser.sv
// EIR vendor field parser, top level.
// Bytes of an extended inquiry response block arrive on in_ch, one per beat,
// with last_byte set on the final byte. The block's length/type/data fields are
// walked until a zero length byte; a vendor field longer than five bytes whose
// command byte matches headset_command_code yields a headset kind, and if its
// company id matches vendor_company_id also the info bytes and, in a field of
// nine bytes or more, the feature byte. One result beat per block leaves on
// out_ch, built from its completed matching fields, later ones overriding
// earlier. Bytes are registered on acceptance, then parsed; a block's last byte
// loads the result register. One byte is taken every cycle, the rate set by the
// single parse stage behind the input register, until out_ch stalls with a
// result held: bytes then flow until the next last byte sits in the input
// register, and in_ch.ready stays low until the result register is free again.
// Configuration: cfg_we/cfg_index/cfg_data, index 0 vendor_company_id and
// index 1 headset_command_code; write only between blocks.
// Reset (rst, synchronous) restores both registers to their defaults and
// clears all parse state and the valid flags of both channel registers.
// Depends on eir_vfp_pkg, eir_vfp_if, eir_vfp_parser and eir_vfp_out_reg.
`default_nettype none

module eir_vendor_field_parser
  import eir_vfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  eir_vfp_byte_if.sink          in_ch,
  eir_vfp_result_if.source      out_ch
);

  logic [15:0] vendor_id;
  logic [7:0]  command_code;
  logic        ir_valid;
  byte_beat_t  ir_beat;
  logic        advance;
  logic        can_load;
  result_t     result;

  always_ff @(posedge clk) begin
    if (rst) begin
      vendor_id    <= RESET_COMPANY_ID;
      command_code <= RESET_COMMAND;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COMPANY_ID: vendor_id    <= cfg_data[15:0];
        CFG_COMMAND:    command_code <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // A byte moves into the parse stage unless it closes a block while the
  // result register is still full.
  assign advance     = ir_valid && (!ir_beat.last_byte || can_load);
  assign in_ch.ready = !ir_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      ir_valid <= 1'b1;
    end else if (advance) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      ir_beat.data_byte <= in_ch.data_byte;
      ir_beat.last_byte <= in_ch.last_byte;
    end
  end

  eir_vfp_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .beat_en      (advance),
    .beat         (ir_beat),
    .vendor_id    (vendor_id),
    .command_code (command_code),
    .result       (result)
  );

  eir_vfp_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && ir_beat.last_byte),
    .result   (result),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

### tb/sv/eir_vendor_field_parser_tb.sv
// Testbench for the EIR vendor field parser: random and directed EIR blocks are
// driven byte by byte, and every result beat is checked against a cycle-free
// model of the field walk. Depends on eir_vfp_pkg, eir_vfp_if and the RTL top.
module eir_vendor_field_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eir_vfp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 400;

  // Tracks the field walk of the current block and holds the block summaries
  // that the parser still owes.
  class vendor_field_scoreboard;
    logic [15:0]  vendor_id;
    logic [7:0]   command_code;
    parse_phase_t phase;
    logic [7:0]   field_length;
    logic [7:0]   field_pos;
    logic [7:0]   ad_type;
    logic [7:0]   company_lo;
    logic [7:0]   company_hi;
    logic [7:0]   command_byte;
    logic [7:0]   type_byte;
    logic [7:0]   frames_byte;
    logic [7:0]   feature_byte;
    result_t      block_summary;
    result_t      summary_q[$];
    int           mismatch_count;
    int           checked_count;

    function new();
      vendor_id      = RESET_COMPANY_ID;
      command_code   = RESET_COMMAND;
      mismatch_count = 0;
      checked_count  = 0;
      clear_block();
    endfunction

    function void clear_block();
      phase         = PH_LENGTH;
      field_length  = '0;
      field_pos     = '0;
      ad_type       = '0;
      company_lo    = '0;
      company_hi    = '0;
      command_byte  = '0;
      type_byte     = '0;
      frames_byte   = '0;
      feature_byte  = '0;
      block_summary = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_COMPANY_ID) begin
        vendor_id = val;
      end else if (idx == CFG_COMMAND) begin
        command_code = val[7:0];
      end
    endfunction

    // Applied at the last byte of a field.
    function void close_field();
      if (ad_type != AD_TYPE_VENDOR || field_length <= MIN_VENDOR_LEN ||
          command_byte != command_code) return;
      block_summary.type_found   = 1'b1;
      block_summary.headset_kind = {type_byte[0], type_byte[1]};
      if ({company_hi, company_lo} != vendor_id) return;
      block_summary.info_valid       = 1'b1;
      block_summary.info_type_byte   = type_byte;
      block_summary.info_frames_byte = frames_byte;
      // A shorter later field keeps an earlier feature byte.
      if (field_length >= FEATURE_LEN) begin
        block_summary.feature_found     = 1'b1;
        block_summary.info_feature_byte = feature_byte;
      end
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      case (phase)
        PH_LENGTH: begin
          if (b == 8'h00) begin
            phase = PH_STOPPED;
          end else begin
            field_length = b;
            field_pos    = '0;
            ad_type      = '0;
            company_lo   = '0;
            company_hi   = '0;
            command_byte = '0;
            type_byte    = '0;
            frames_byte  = '0;
            feature_byte = '0;
            phase        = PH_FIELD;
          end
        end
        PH_FIELD: begin
          field_pos = field_pos + 8'd1;
          case (field_pos)
            POS_AD_TYPE:     ad_type      = b;
            POS_COMPANY_LO:  company_lo   = b;
            POS_COMPANY_HI:  company_hi   = b;
            POS_COMMAND:     command_byte = b;
            POS_INFO_TYPE:   type_byte    = b;
            POS_INFO_FRAMES: frames_byte  = b;
            POS_FEATURE:     feature_byte = b;
            default: ;
          endcase
          if (field_pos >= field_length) begin
            close_field();
            phase = PH_LENGTH;
          end
        end
        default: ;
      endcase
      if (last) begin
        summary_q.push_back(block_summary);
        clear_block();
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("block %0d %s: expected %0h, got %0h", checked_count, name, want, got);
      end
    endfunction

    function void check_summary(result_t got);
      result_t want;
      if (summary_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: %0h", got);
        return;
      end
      want = summary_q.pop_front();
      compare_field("type_found", 8'(want.type_found), 8'(got.type_found));
      compare_field("headset_kind", 8'(want.headset_kind), 8'(got.headset_kind));
      compare_field("info_valid", 8'(want.info_valid), 8'(got.info_valid));
      compare_field("info_type_byte", want.info_type_byte, got.info_type_byte);
      compare_field("info_frames_byte", want.info_frames_byte, got.info_frames_byte);
      compare_field("feature_found", 8'(want.feature_found), 8'(got.feature_found));
      compare_field("info_feature_byte", want.info_feature_byte, got.info_feature_byte);
      checked_count++;
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  eir_vfp_byte_if   in_ch();
  eir_vfp_result_if out_ch();

  eir_vendor_field_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  vendor_field_scoreboard field_sb;
  logic [7:0] block_bytes[$];
  int         burst_left = 0;
  int         bytes_sent = 0;
  int         cycle_count = 0;
  bit         long_hold_req = 1'b0;
  bit         long_field_due = 1'b0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t seen;
    if (!rst && out_ch.valid && out_ch.ready) begin
      seen.type_found        = out_ch.type_found;
      seen.headset_kind      = out_ch.headset_kind;
      seen.info_valid        = out_ch.info_valid;
      seen.info_type_byte    = out_ch.info_type_byte;
      seen.info_frames_byte  = out_ch.info_frames_byte;
      seen.feature_found     = out_ch.feature_found;
      seen.info_feature_byte = out_ch.info_feature_byte;
      field_sb.check_summary(seen);
    end
  end

  // Result side: segments of steady, random and patterned stalls, plus one long
  // hold on request so that the parser backs up into its input.
  initial begin
    int seg_left;
    int seg_mode;
    out_ch.ready = 1'b0;
    seg_left = 0;
    seg_mode = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (seg_left == 0) begin
        seg_mode = $urandom_range(0, 3);
        seg_left = $urandom_range(10, 60);
      end
      seg_left--;
      case (seg_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= 1'($urandom_range(0, 1));
        default: out_ch.ready <= (seg_left % 4 != 0);
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    field_sb.take_byte(b, l);
    bytes_sent++;
  endtask

  task automatic send_block();
    int i;
    for (i = 0; i < block_bytes.size(); i++)
      send_byte(block_bytes[i], i == block_bytes.size() - 1);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (field_sb.summary_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Two back-to-back register writes; the parser must be idle.
  task automatic load_settings(input logic [15:0] company, input logic [15:0] command_word);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COMPANY_ID;
    cfg_data  <= company;
    @(posedge clk);
    field_sb.set_reg(CFG_COMPANY_ID, company);
    cfg_index <= CFG_COMMAND;
    cfg_data  <= command_word;
    @(posedge clk);
    field_sb.set_reg(CFG_COMMAND, command_word);
    cfg_we <= 1'b0;
  endtask

  // Appends one length/type/data field, mostly vendor fields that often carry the
  // current company id and command code.
  function automatic void add_field();
    logic [7:0]  body[$];
    logic [15:0] company;
    int          len;
    int          pick;
    int          i;
    pick = $urandom_range(0, 9);
    if (long_field_due) begin
      len = 255;
      pick = 0;
      long_field_due = 1'b0;
    end else if (pick <= 5) begin
      case ($urandom_range(0, 7))
        0: len = $urandom_range(1, 5);
        1: len = $urandom_range(13, 40);
        default: len = $urandom_range(6, 12);
      endcase
    end else begin
      len = $urandom_range(1, 10);
    end
    for (i = 0; i < len; i++) body.push_back(8'($urandom));
    if (pick <= 5 || pick == 9) begin
      company = ($urandom_range(0, 3) != 0) ? field_sb.vendor_id : 16'($urandom);
      if ($urandom_range(0, 7) == 0) company ^= 16'(1) << $urandom_range(0, 15);
      body[0] = ($urandom_range(0, 9) != 0) ? AD_TYPE_VENDOR : 8'($urandom);
      if (len >= 2) body[1] = company[7:0];
      if (len >= 3) body[2] = company[15:8];
      if (len >= 4)
        body[3] = ($urandom_range(0, 4) != 0) ? field_sb.command_code : 8'($urandom);
    end
    block_bytes.push_back(8'(len));
    block_bytes = {block_bytes, body};
  endfunction

  function automatic void fill_block();
    int n;
    int i;
    block_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 20);
      for (i = 0; i < n; i++) block_bytes.push_back(8'($urandom));
    end else begin
      n = $urandom_range(0, 4);
      for (i = 0; i < n; i++) add_field();
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // Zero length ends the walk; whatever follows is ignored.
          block_bytes.push_back(8'h00);
          n = $urandom_range(0, 5);
          for (i = 0; i < n; i++) block_bytes.push_back(8'($urandom));
        end
        3: begin
          // Cut the block short so the last field runs past its end.
          if (block_bytes.size() > 1) begin
            n = $urandom_range(1, block_bytes.size() - 1);
            repeat (n) void'(block_bytes.pop_back());
          end
        end
        default: ;
      endcase
      if (block_bytes.size() == 0) block_bytes.push_back(8'($urandom));
    end
  endfunction

  task automatic run_phase(input int n_bytes);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      fill_block();
      send_block();
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    field_sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // A block that is only a zero length byte.
    block_bytes = '{8'h00};
    send_block();
    // Full vendor field with feature byte, then a shorter matching field that
    // overrides kind and info but keeps the feature, then a stop and a stray byte.
    block_bytes = '{8'h09, 8'hFF, 8'h5D, 8'h00, 8'h08, 8'h03, 8'hA5, 8'h11, 8'h22, 8'hF7,
                    8'h06, 8'hFF, 8'h5D, 8'h00, 8'h08, 8'h01, 8'h0F, 8'h00, 8'h33};
    send_block();
    // Matching field cut off by the end of the block: nothing is committed.
    block_bytes = '{8'h07, 8'hFF, 8'h5D, 8'h00, 8'h08, 8'h02};
    send_block();
    run_phase(140);

    load_settings(16'h0000, 16'h0000);
    long_field_due = 1'b1;
    run_phase(170);

    load_settings(16'hFFFF, 16'hFFFF);
    long_hold_req = 1'b1;
    run_phase(170);

    load_settings(16'($urandom), 16'($urandom));
    long_field_due = 1'b1;
    run_phase(170);

    load_settings(RESET_COMPANY_ID, {8'($urandom), RESET_COMMAND});
    run_phase(170);

    if (field_sb.mismatch_count == 0 && field_sb.summary_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/eir_vfp_pkg.sv
rtl/core/eir_vfp_if.sv
rtl/core/eir_vfp_parser.sv
rtl/core/eir_vfp_out_reg.sv
rtl/core/eir_vendor_field_parser.sv
tb/sv/eir_vendor_field_parser_tb.sv
